[rtl/lmbs_pkg.sv]
// ----------------------------------------------------------------------------
// lmbs_pkg
// Shared types, codes and helper functions of the LED matrix bit-plane scanner.
// ----------------------------------------------------------------------------
package lmbs_pkg;

  // Matrix and buffer geometry
  localparam int unsigned NumCols   = 8;
  localparam int unsigned NumRows   = 5;   // four gray planes and the mono buffer
  localparam int unsigned RowWidth  = 8 * NumCols;
  localparam logic [2:0]  MonoRow   = 3'd4;
  localparam logic [2:0]  ScanReset = 3'd5;

  // Configuration register indexes
  localparam logic RegMirrorCols = 1'b0;
  localparam logic RegMirrorRows = 1'b1;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_EXPAND = 2'd2,
    KIND_MODE   = 2'd3
  } kind_e;

  // Level modes
  localparam logic [1:0] Level1  = 2'd0;
  localparam logic [1:0] Level3  = 2'd1;
  localparam logic [1:0] Level7  = 2'd2;
  localparam logic [1:0] Level15 = 2'd3;

  // Buffer memory access, one row per buffer
  typedef struct packed {
    logic                rd_en;
    logic [2:0]          rd_row;
    logic                wr_en;
    logic [2:0]          wr_row;
    logic [NumCols-1:0]  wr_be;
    logic [RowWidth-1:0] wr_data;
  } mem_req_t;

  // Tick information carried alongside the buffer read
  typedef struct packed {
    logic [NumCols-1:0] col_sel;
    logic [2:0]         src_col;
    logic               blank;
  } tick_meta_t;

  // Buffer shown for one frame
  typedef struct packed {
    logic       blank;
    logic [2:0] row;
  } row_sel_t;

  function automatic logic [7:0] reverse8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = x[7-i];
    end
    return r;
  endfunction

  // Frames per cycle of a level mode
  function automatic logic [4:0] level_count(input logic [1:0] mode);
    logic [4:0] n;
    case (mode)
      Level1:  n = 5'd1;
      Level3:  n = 5'd3;
      Level7:  n = 5'd7;
      Level15: n = 5'd15;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

  // Binary-weighted plane for a frame; beyond the level count shows blank
  function automatic row_sel_t row_for_frame(input logic [1:0] mode, input logic [3:0] frame);
    row_sel_t s;
    s.blank = 1'b0;
    s.row   = 3'd0;
    case (mode)
      Level1: begin
        s.row = MonoRow;
      end
      Level3: begin
        if (frame < 4'd2)      s.row = 3'd0;
        else if (frame < 4'd3) s.row = 3'd1;
        else                   s.blank = 1'b1;
      end
      Level7: begin
        if (frame < 4'd4)      s.row = 3'd0;
        else if (frame < 4'd6) s.row = 3'd1;
        else if (frame < 4'd7) s.row = 3'd2;
        else                   s.blank = 1'b1;
      end
      Level15: begin
        if (frame < 4'd8)       s.row = 3'd0;
        else if (frame < 4'd12) s.row = 3'd1;
        else if (frame < 4'd14) s.row = 3'd2;
        else if (frame < 4'd15) s.row = 3'd3;
        else                    s.blank = 1'b1;
      end
      default: begin
        s.blank = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

[rtl/lmbs_buf_mem.sv]
// ----------------------------------------------------------------------------
// lmbs_buf_mem
// Buffer memory: one 64-bit row per buffer, byte-enabled writes, registered
// read. A row never written reads as zero through its valid bit.
// ----------------------------------------------------------------------------
module lmbs_buf_mem
  import lmbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mem_req_t            req_i,
  output logic [RowWidth-1:0] rd_data_o
);

  logic [RowWidth-1:0] mem_q [0:NumRows-1];
  logic [NumRows-1:0]  valid_q;
  logic [RowWidth-1:0] rd_q;
  logic                rd_valid_q;

  // Write enabled bytes; first write to a row clears the rest of it
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      for (int b = 0; b < NumCols; b++) begin
        if (req_i.wr_be[b] || !valid_q[req_i.wr_row]) begin
          mem_q[req_i.wr_row][b*8 +: 8] <= req_i.wr_be[b] ? req_i.wr_data[b*8 +: 8] : 8'h00;
        end
      end
    end
  end

  // Mark rows as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_row] <= 1'b1;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q       <= mem_q[req_i.rd_row];
      rd_valid_q <= valid_q[req_i.rd_row];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

[rtl/lmbs_scan.sv]
// ----------------------------------------------------------------------------
// lmbs_scan
// Scan and frame counters, level mode, and decode of items into buffer
// memory reads and writes.
// ----------------------------------------------------------------------------
module lmbs_scan
  import lmbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [1:0] kind_i,
  input  logic [2:0] plane_i,
  input  logic [2:0] column_i,
  input  logic [7:0] byte_value_i,
  input  logic [1:0] level_code_i,
  input  logic       mirror_cols_i,
  input  logic       mirror_rows_i,
  output mem_req_t   req_o,
  output tick_meta_t meta_o
);

  logic [2:0] scan_col_q, scan_col_d;
  logic [3:0] frame_q, frame_d;
  logic [1:0] mode_q, mode_d;
  logic [4:0] frame_next;
  logic [7:0] wr_byte;
  row_sel_t   sel;
  logic       is_tick;
  logic       is_raw;
  logic       is_expand;

  assign is_tick   = (kind_i == KIND_TICK);
  assign is_raw    = (kind_i == KIND_RAW);
  assign is_expand = (kind_i == KIND_EXPAND);
  assign sel       = row_for_frame(mode_q, frame_q);
  assign wr_byte   = mirror_rows_i ? reverse8(byte_value_i) : byte_value_i;

  // Build the buffer access for this item
  always_comb begin
    req_o         = '0;
    req_o.rd_en   = fire_i && is_tick;
    req_o.rd_row  = sel.row;
    req_o.wr_en   = fire_i && (is_raw || is_expand) && (plane_i <= MonoRow);
    req_o.wr_row  = plane_i;
    if (is_expand) begin
      req_o.wr_be = '1;
      for (int n = 0; n < NumCols; n++) begin
        req_o.wr_data[n*8 +: 8] = wr_byte[n] ? 8'hff : 8'h00;
      end
    end else begin
      req_o.wr_be[column_i]            = 1'b1;
      req_o.wr_data[column_i*8 +: 8]   = wr_byte;
    end
  end

  // Tick details for the read stage
  always_comb begin
    meta_o.col_sel = '0;
    meta_o.col_sel[scan_col_q] = 1'b1;
    meta_o.src_col = mirror_cols_i ? (3'd7 - scan_col_q) : scan_col_q;
    meta_o.blank   = sel.blank;
  end

  // Advance column and frame on a tick; set the mode on a mode beat
  always_comb begin
    scan_col_d = scan_col_q;
    frame_d    = frame_q;
    mode_d     = mode_q;
    frame_next = {1'b0, frame_q} + 5'd1;
    if (fire_i && is_tick) begin
      scan_col_d = scan_col_q + 3'd1;
      if (scan_col_q == 3'd0) begin
        frame_d = (frame_next >= level_count(mode_q)) ? 4'd0 : frame_next[3:0];
      end
    end
    if (fire_i && (kind_i == KIND_MODE)) begin
      mode_d = level_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q <= ScanReset;
      frame_q    <= 4'd0;
      mode_q     <= Level1;
    end else begin
      scan_col_q <= scan_col_d;
      frame_q    <= frame_d;
      mode_q     <= mode_d;
    end
  end

endmodule

[rtl/led_matrix_bitplane_scanner.sv]
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scanner
// Column scanner for an 8x8 LED matrix with binary-weighted gray planes.
// ----------------------------------------------------------------------------
// A tick beat is held in the buffer memory read and the read stage, then in the
// output register; an output stall can hold it in the read stage.
// Throughput: one beat per cycle unless stalled; the single-port buffer memory
// takes one read or one write per cycle. Writes and mode beats give no result.
// Reset: column 5, frame 0, one-level mode, all buffers read as zero at once.
module led_matrix_bitplane_scanner
  import lmbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  plane_i,
  input  logic [2:0]  column_i,
  input  logic [7:0]  byte_value_i,
  input  logic [1:0]  level_code_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  column_select_o,
  output logic [7:0]  row_data_o
);

  logic                mirror_cols_q;
  logic                mirror_rows_q;
  logic                in_fire;
  logic                out_load;
  logic                s1_valid_q;
  tick_meta_t          s1_meta_q;
  tick_meta_t          meta;
  mem_req_t            req;
  logic [RowWidth-1:0] rd_data;
  logic                out_valid_q;
  logic [7:0]          col_sel_q;
  logic [7:0]          row_q;

  // Register writes and reads
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_cols_q <= 1'b0;
      mirror_rows_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegMirrorCols) mirror_cols_q <= pwdata[0];
      if (paddr[2] == RegMirrorRows) mirror_rows_q <= pwdata[0];
    end
  end
  assign prdata = {31'd0, (paddr[2] == RegMirrorRows) ? mirror_rows_q : mirror_cols_q};

  // Handshake: stall only when the read stage is full and cannot drain
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  lmbs_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .kind_i        (kind_i),
    .plane_i       (plane_i),
    .column_i      (column_i),
    .byte_value_i  (byte_value_i),
    .level_code_i  (level_code_i),
    .mirror_cols_i (mirror_cols_q),
    .mirror_rows_i (mirror_rows_q),
    .req_o         (req),
    .meta_o        (meta)
  );

  lmbs_buf_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  // Read stage: hold tick details while the memory read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || out_load) begin
      s1_valid_q <= in_fire && (kind_i == KIND_TICK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.rd_en) begin
      s1_meta_q <= meta;
    end
  end

  // Output register: pick the column byte, blank when out of range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      col_sel_q <= s1_meta_q.col_sel;
      row_q     <= s1_meta_q.blank ? 8'h00 : rd_data[s1_meta_q.src_col*8 +: 8];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign column_select_o = col_sel_q;
  assign row_data_o      = row_q;

  // A tick beat always lands in the read stage
  a_tick_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (kind_i == KIND_TICK) |=> s1_valid_q)
    else $error("tick beat did not reach read stage");

  // A blocked read stage keeps its tick
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_load |=> s1_valid_q && $stable(s1_meta_q))
    else $error("read stage lost a blocked tick");

  // Column select is one-hot whenever a result is shown
  a_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(column_select_o))
    else $error("column select not one-hot");

endmodule
